FILE: sv/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types and codes used by the preemptive priority scheduler core; the slot
// entry type also sets the width of its slot table memory.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    // command codes
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_IDLE       = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;
    localparam logic [1:0] STATUS_ZERO_BURST = 2'd3;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    // one slot table entry
    typedef struct packed {
        logic [7:0]  job_id;
        logic [7:0]  priority_lvl;
        logic [31:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
    } slot_entry_t;

endpackage

`default_nettype wire

FILE: sv/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/preemptive_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Preemptive priority scheduler over a table of job slots held in one RAM.
// ----------------------------------------------------------------------------
// tick: reads every slot in slot order, one RAM read per slot (ST_SCAN, ST_LAST),
//   then updates the job (ST_CALC); a finishing job adds ST_TAT and ST_WAIT
// arrive: a zero burst is answered from idle without a search, else the one-slot-a-cycle
//   free search stops at the first free slot, or at the last slot when full
// one item at a time; busy is high until its result strobe; results cannot stall
// reset: valid bits and time counter clear at once, table contents undefined
`default_nettype none

module preemptive_priority_scheduler_core
    import pps_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cmd,
    input  wire logic [7:0]  job_id,
    input  wire logic [7:0]  job_priority,
    input  wire logic [15:0] job_burst,
    output logic             done,
    output logic [1:0]       status,
    output logic [7:0]       ran_id,
    output logic             finished,
    output logic [31:0]      finish_time,
    output logic [31:0]      turnaround,
    output logic [31:0]      waiting,
    output logic [31:0]      now_time
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SCAN,
        ST_LAST,
        ST_CALC,
        ST_TAT,
        ST_WAIT
    } state_t;

    state_t            state_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [31:0]       time_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_pend_reg;
    slot_entry_t       new_reg;
    slot_entry_t       best_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              best_found_reg;
    logic [31:0]       fin_reg;
    logic [31:0]       tat_reg;

    logic              done_reg;
    logic [1:0]        status_reg;
    logic [7:0]        ran_id_reg;
    logic              finished_reg;
    logic [31:0]       finish_time_reg;
    logic [31:0]       turnaround_reg;
    logic [31:0]       waiting_reg;
    logic [31:0]       now_time_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    slot_entry_t       ram_wdata;
    slot_entry_t       ram_rdata;

    logic              accept;
    logic              cand_better;
    logic [15:0]       rem_dec;
    logic [31:0]       time_inc;
    logic [31:0]       burst_ext;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // slot table memory
    pps_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // scan compare: later slot wins only on higher priority, or equal priority and earlier arrival
    assign cand_better = rd_pend_reg && valid_reg[rd_idx_reg] &&
                         (!best_found_reg ||
                          (ram_rdata.priority_lvl > best_reg.priority_lvl) ||
                          ((ram_rdata.priority_lvl == best_reg.priority_lvl) &&
                           (ram_rdata.arrival < best_reg.arrival)));

    assign rem_dec   = (best_reg.remaining == 16'd0) ? 16'd0 : best_reg.remaining - 16'd1;
    assign time_inc  = (time_reg == TIME_MAX) ? time_reg : time_reg + 32'd1;
    assign burst_ext = {16'd0, best_reg.burst};

    // table writes: new job on arrive, updated remaining work on tick
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = new_reg;
        case (state_reg)
            ST_FIND:
            begin
                ram_we    = !valid_reg[idx_reg];
                ram_waddr = idx_reg;
                ram_wdata = new_reg;
            end
            ST_CALC:
            begin
                ram_we              = best_found_reg;
                ram_waddr           = best_idx_reg;
                ram_wdata           = best_reg;
                ram_wdata.remaining = rem_dec;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control state machine and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            time_reg        <= '0;
            idx_reg         <= '0;
            rd_idx_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            new_reg         <= '0;
            best_reg        <= '0;
            best_idx_reg    <= '0;
            best_found_reg  <= 1'b0;
            fin_reg         <= '0;
            tat_reg         <= '0;
            done_reg        <= 1'b0;
            status_reg      <= STATUS_OK;
            ran_id_reg      <= '0;
            finished_reg    <= 1'b0;
            finish_time_reg <= '0;
            turnaround_reg  <= '0;
            waiting_reg     <= '0;
            now_time_reg    <= '0;
        end
        else
        begin
            done_reg    <= 1'b0;
            rd_pend_reg <= (state_reg == ST_SCAN);
            rd_idx_reg  <= idx_reg;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        // result fields default to zero, time sampled now
                        status_reg      <= STATUS_OK;
                        ran_id_reg      <= '0;
                        finished_reg    <= 1'b0;
                        finish_time_reg <= '0;
                        turnaround_reg  <= '0;
                        waiting_reg     <= '0;
                        now_time_reg    <= time_reg;
                        idx_reg         <= '0;
                        best_found_reg  <= 1'b0;
                        new_reg.job_id       <= job_id;
                        new_reg.priority_lvl <= job_priority;
                        new_reg.arrival      <= time_reg;
                        new_reg.burst        <= job_burst;
                        new_reg.remaining    <= job_burst;
                        if (cmd == CMD_TICK)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else if (job_burst == 16'd0)
                        begin
                            status_reg <= STATUS_ZERO_BURST;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_FIND;
                        end
                    end
                end
                ST_FIND:
                begin
                    // lowest free slot, one slot a cycle
                    if (!valid_reg[idx_reg])
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        status_reg         <= STATUS_OK;
                        done_reg           <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        status_reg <= STATUS_FULL;
                        done_reg   <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    // issue reads in slot order, compare what returns
                    if (cand_better)
                    begin
                        best_reg       <= ram_rdata;
                        best_idx_reg   <= rd_idx_reg;
                        best_found_reg <= 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_LAST;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_LAST:
                begin
                    // compare the final read
                    if (cand_better)
                    begin
                        best_reg       <= ram_rdata;
                        best_idx_reg   <= rd_idx_reg;
                        best_found_reg <= 1'b1;
                    end
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    time_reg <= time_inc;
                    fin_reg  <= time_inc;
                    if (!best_found_reg)
                    begin
                        status_reg <= STATUS_IDLE;
                        done_reg   <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                    else if (rem_dec != 16'd0)
                    begin
                        ran_id_reg <= best_reg.job_id;
                        done_reg   <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        // job completes: free its slot
                        valid_reg[best_idx_reg] <= 1'b0;
                        state_reg               <= ST_TAT;
                    end
                end
                ST_TAT:
                begin
                    tat_reg   <= fin_reg - best_reg.arrival;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    // waiting time floored at zero
                    ran_id_reg      <= best_reg.job_id;
                    finished_reg    <= 1'b1;
                    finish_time_reg <= fin_reg;
                    turnaround_reg  <= tat_reg;
                    waiting_reg     <= (tat_reg >= burst_ext) ? tat_reg - burst_ext : 32'd0;
                    done_reg        <= 1'b1;
                    state_reg       <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign ran_id      = ran_id_reg;
    assign finished    = finished_reg;
    assign finish_time = finish_time_reg;
    assign turnaround  = turnaround_reg;
    assign waiting     = waiting_reg;
    assign now_time    = now_time_reg;

endmodule

`default_nettype wire
